>>> design/adsr_dac_pkg.sv
// shared types and constants for the adsr envelope dac stage
`timescale 1ns / 1ps
`default_nettype none
package adsr_dac_pkg;

    localparam int unsigned MAX_LEVEL_INT = 61440;
    localparam int unsigned VEL_DIV       = 128;

    localparam logic [15:0] MAX_LEVEL  = 16'(MAX_LEVEL_INT);
    localparam logic [15:0] PEAK_UNIT  = 16'(MAX_LEVEL_INT / VEL_DIV);
    localparam logic [15:0] FULL_LEVEL = 16'hFFFF;
    localparam logic [13:0] DAC_CMD    = 14'h3000;

    localparam logic [15:0] ATTACK_STEP_RST  = 16'd792;
    localparam logic [15:0] DECAY_STEP_RST   = 16'd38;
    localparam logic [15:0] RELEASE_STEP_RST = 16'd64;
    localparam logic [15:0] SUSTAIN_BASE_RST = 16'd15360;

    typedef enum logic [2:0] {
        STAGE_IDLE    = 3'd0,
        STAGE_ATTACK  = 3'd1,
        STAGE_DECAY   = 3'd2,
        STAGE_SUSTAIN = 3'd3,
        STAGE_RELEASE = 3'd4
    } env_stage_t;

    typedef enum logic [1:0] {
        MODE_TICK      = 2'd0,
        MODE_NOTE_ON   = 2'd1,
        MODE_OFF_MATCH = 2'd2,
        MODE_OFF_ANY   = 2'd3
    } item_mode_t;

    typedef enum logic [2:0] {
        REG_ENABLE       = 3'd0,
        REG_ATTACK_STEP  = 3'd1,
        REG_DECAY_STEP   = 3'd2,
        REG_RELEASE_STEP = 3'd3,
        REG_SUSTAIN_BASE = 3'd4
    } reg_index_t;

endpackage
`default_nettype wire

>>> design/adsr_envelope_dac_stage_core.sv
// adsr envelope with velocity scaling and dac command word output
// path: a beat passes the input reg, the envelope reg and the output reg to reach the result
// throughput: one beat per cycle while the result side is not stalled; the envelope state updates once per beat
// each stage holds while the next is stalled; while a result waits, input fills free registers
// reset: synchronous active-low aresetn clears the envelope state, valids and
// loads the register defaults (enable 0, steps 792/38/64, sustain base 15360)
`timescale 1ns / 1ps
`default_nettype none
module adsr_envelope_dac_stage_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // apb configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // note[6:0], velocity[13:7], sample[29:14], zero[31:30]
    input  wire logic [1:0]  s_tuser,  // mode[1:0]
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata   // dac_word[13:0], level[29:14], stage[32:30], zero[39:33]
);

    // configuration registers
    logic        enable_reg;
    logic [15:0] attack_step_reg;
    logic [15:0] decay_step_reg;
    logic [15:0] release_step_reg;
    logic [15:0] sustain_base_reg;

    logic       cfg_write;
    logic [2:0] cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg       <= 1'b0;
            attack_step_reg  <= adsr_dac_pkg::ATTACK_STEP_RST;
            decay_step_reg   <= adsr_dac_pkg::DECAY_STEP_RST;
            release_step_reg <= adsr_dac_pkg::RELEASE_STEP_RST;
            sustain_base_reg <= adsr_dac_pkg::SUSTAIN_BASE_RST;
        end else if (cfg_write) begin
            case (cfg_index)
                adsr_dac_pkg::REG_ENABLE:       enable_reg       <= pwdata[0];
                adsr_dac_pkg::REG_ATTACK_STEP:  attack_step_reg  <= pwdata[15:0];
                adsr_dac_pkg::REG_DECAY_STEP:   decay_step_reg   <= pwdata[15:0];
                adsr_dac_pkg::REG_RELEASE_STEP: release_step_reg <= pwdata[15:0];
                adsr_dac_pkg::REG_SUSTAIN_BASE: sustain_base_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            adsr_dac_pkg::REG_ENABLE:       prdata = {31'd0, enable_reg};
            adsr_dac_pkg::REG_ATTACK_STEP:  prdata = {16'd0, attack_step_reg};
            adsr_dac_pkg::REG_DECAY_STEP:   prdata = {16'd0, decay_step_reg};
            adsr_dac_pkg::REG_RELEASE_STEP: prdata = {16'd0, release_step_reg};
            adsr_dac_pkg::REG_SUSTAIN_BASE: prdata = {16'd0, sustain_base_reg};
            default:                        prdata = 32'd0;
        endcase
    end

    // pipeline handshake
    logic in_valid_reg;
    logic env_valid_reg;
    logic out_valid_reg;
    logic env_adv;
    logic out_adv;

    assign out_adv  = env_valid_reg && (!out_valid_reg || m_tready);
    assign env_adv  = in_valid_reg && (!env_valid_reg || out_adv);
    assign s_tready = !in_valid_reg || env_adv;
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            env_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) in_valid_reg <= s_tvalid;
            if (env_adv || out_adv) env_valid_reg <= env_adv;
            if (out_adv || m_tready) out_valid_reg <= out_adv;
        end
    end

    // input register
    adsr_dac_pkg::item_mode_t in_mode_reg;
    logic [6:0]  in_note_reg;
    logic [6:0]  in_vel_reg;
    logic [15:0] in_sample_reg;

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_mode_reg   <= adsr_dac_pkg::item_mode_t'(s_tuser);
            in_note_reg   <= s_tdata[6:0];
            in_vel_reg    <= s_tdata[13:7];
            in_sample_reg <= s_tdata[29:14];
        end
    end

    // envelope state
    logic [15:0]              level_reg, level_next;
    adsr_dac_pkg::env_stage_t stage_reg, stage_next;
    logic [15:0]              peak_reg, peak_next;
    logic [15:0]              sustain_reg, sustain_next;
    logic [6:0]               note_reg, note_next;

    logic [15:0] sum_attack;
    logic [15:0] dif_decay;
    logic [15:0] dif_release;

    assign sum_attack  = level_reg + attack_step_reg;
    assign dif_decay   = level_reg - decay_step_reg;
    assign dif_release = level_reg - release_step_reg;

    always_comb begin
        level_next   = level_reg;
        stage_next   = stage_reg;
        peak_next    = peak_reg;
        sustain_next = sustain_reg;
        note_next    = note_reg;
        case (in_mode_reg)
            adsr_dac_pkg::MODE_TICK: begin
                if (!enable_reg) begin
                    level_next = adsr_dac_pkg::FULL_LEVEL;
                end else begin
                    case (stage_reg)
                        adsr_dac_pkg::STAGE_ATTACK: begin
                            level_next = sum_attack;
                            if (sum_attack > peak_reg) begin
                                level_next = peak_reg;
                                stage_next = adsr_dac_pkg::STAGE_DECAY;
                            end
                        end
                        adsr_dac_pkg::STAGE_DECAY: begin
                            level_next = dif_decay;
                            if (dif_decay < sustain_reg || dif_decay > adsr_dac_pkg::MAX_LEVEL)
                            begin
                                level_next = sustain_reg;
                                stage_next = adsr_dac_pkg::STAGE_SUSTAIN;
                            end
                        end
                        adsr_dac_pkg::STAGE_SUSTAIN: level_next = sustain_reg;
                        adsr_dac_pkg::STAGE_RELEASE: begin
                            level_next = dif_release;
                            if (dif_release > adsr_dac_pkg::MAX_LEVEL) begin
                                level_next = 16'd0;
                                stage_next = adsr_dac_pkg::STAGE_IDLE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            adsr_dac_pkg::MODE_NOTE_ON: begin
                stage_next   = adsr_dac_pkg::STAGE_ATTACK;
                sustain_next = {9'd0, in_vel_reg} * {7'd0, sustain_base_reg[15:7]};
                peak_next    = 16'({9'd0, in_vel_reg} * adsr_dac_pkg::PEAK_UNIT);
                note_next    = in_note_reg;
            end
            adsr_dac_pkg::MODE_OFF_MATCH: begin
                if (note_reg == in_note_reg) stage_next = adsr_dac_pkg::STAGE_RELEASE;
            end
            adsr_dac_pkg::MODE_OFF_ANY: stage_next = adsr_dac_pkg::STAGE_RELEASE;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg   <= 16'd0;
            stage_reg   <= adsr_dac_pkg::STAGE_IDLE;
            peak_reg    <= 16'd0;
            sustain_reg <= 16'd0;
            note_reg    <= 7'd0;
        end else if (env_adv) begin
            level_reg   <= level_next;
            stage_reg   <= stage_next;
            peak_reg    <= peak_next;
            sustain_reg <= sustain_next;
            note_reg    <= note_next;
        end
    end

    // envelope result register
    logic        env_tick_reg;
    logic [15:0] env_sample_reg;
    logic [15:0] env_level_reg;
    logic [2:0]  env_stage_reg;

    always_ff @(posedge aclk) begin
        if (env_adv) begin
            env_tick_reg   <= (in_mode_reg == adsr_dac_pkg::MODE_TICK);
            env_sample_reg <= in_sample_reg;
            env_level_reg  <= level_next;
            env_stage_reg  <= stage_next;
        end
    end

    // scale sample by level, keep the top 12 bits
    logic [31:0] product;
    logic [13:0] dac_next;

    assign product  = {16'd0, env_level_reg} * {16'd0, env_sample_reg};
    assign dac_next = env_tick_reg ? (adsr_dac_pkg::DAC_CMD | {2'd0, product[31:20]})
                                   : adsr_dac_pkg::DAC_CMD;

    logic [13:0] out_dac_reg;
    logic [15:0] out_level_reg;
    logic [2:0]  out_stage_reg;

    always_ff @(posedge aclk) begin
        if (out_adv) begin
            out_dac_reg   <= dac_next;
            out_level_reg <= env_level_reg;
            out_stage_reg <= env_stage_reg;
        end
    end

    assign m_tdata = {7'd0, out_stage_reg, out_level_reg, out_dac_reg};

    // checks
    a_dac_cmd_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[13:12] == 2'b11)
        else $error("dac command bits missing");

    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !env_adv |=> $stable(level_reg) && $stable(stage_reg))
        else $error("envelope state moved without a beat");

    a_full_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && s_tready) |-> env_adv)
        else $error("input register overwritten");

    a_tick_level_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (env_adv && !enable_reg && in_mode_reg == adsr_dac_pkg::MODE_TICK)
            |=> level_reg == adsr_dac_pkg::FULL_LEVEL)
        else $error("disabled tick did not force full level");

endmodule
`default_nettype wire

>>> verif/adsr_envelope_dac_stage_core_tb.sv
// self-checking testbench for the adsr envelope dac stage core
`timescale 1ns / 1ps
module adsr_envelope_dac_stage_core_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_BEATS  = 140;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        adsr_dac_pkg::item_mode_t mode;
        logic [6:0]               note;
        logic [6:0]               velocity;
        logic [15:0]              sample;
    } note_item_t;

    typedef struct packed {
        logic [13:0]              dac_word;
        logic [15:0]              level;
        adsr_dac_pkg::env_stage_t stage;
    } dac_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // note[6:0], velocity[13:7], sample[29:14], zero[31:30]
    logic [1:0]  s_tuser = '0;   // mode[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // dac_word[13:0], level[29:14], stage[32:30], zero[39:33]

    // envelope predictor state and register shadow
    logic [15:0]              gain_level;
    adsr_dac_pkg::env_stage_t gain_stage;
    logic [15:0]              peak_level;
    logic [15:0]              sustain_level;
    logic [6:0]               held_key;
    logic                     shadow_enable;
    logic [15:0]              shadow_attack;
    logic [15:0]              shadow_decay;
    logic [15:0]              shadow_release;
    logic [15:0]              shadow_sustain_base;

    dac_beat_t pending_dac_beats[$];
    int        mismatches = 0;
    int        cycle_count = 0;
    bit        idle_on = 1'b1;
    bit        hold_request = 1'b0;
    int        hold_left = 0;

    adsr_envelope_dac_stage_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("adsr_envelope_dac_stage_core regression: fail");
            $finish;
        end
    end

    function automatic dac_beat_t envelope_next(note_item_t it);
        dac_beat_t   r;
        logic [31:0] product;
        r.dac_word = adsr_dac_pkg::DAC_CMD;
        case (it.mode)
            adsr_dac_pkg::MODE_TICK: begin
                if (!shadow_enable) begin
                    gain_level = adsr_dac_pkg::FULL_LEVEL;
                end else begin
                    case (gain_stage)
                        adsr_dac_pkg::STAGE_ATTACK: begin
                            gain_level = gain_level + shadow_attack;
                            if (gain_level > peak_level) begin
                                gain_level = peak_level;
                                gain_stage = adsr_dac_pkg::STAGE_DECAY;
                            end
                        end
                        adsr_dac_pkg::STAGE_DECAY: begin
                            gain_level = gain_level - shadow_decay;
                            if (gain_level < sustain_level ||
                                gain_level > adsr_dac_pkg::MAX_LEVEL) begin
                                gain_level = sustain_level;
                                gain_stage = adsr_dac_pkg::STAGE_SUSTAIN;
                            end
                        end
                        adsr_dac_pkg::STAGE_SUSTAIN: gain_level = sustain_level;
                        adsr_dac_pkg::STAGE_RELEASE: begin
                            gain_level = gain_level - shadow_release;
                            if (gain_level > adsr_dac_pkg::MAX_LEVEL) begin
                                gain_level = '0;
                                gain_stage = adsr_dac_pkg::STAGE_IDLE;
                            end
                        end
                        default: ;
                    endcase
                end
                product = 32'(gain_level) * 32'(it.sample);
                r.dac_word = adsr_dac_pkg::DAC_CMD | 14'(product[31:20]);
            end
            adsr_dac_pkg::MODE_NOTE_ON: begin
                gain_stage    = adsr_dac_pkg::STAGE_ATTACK;
                sustain_level = 16'(32'(it.velocity) *
                                (32'(shadow_sustain_base) / adsr_dac_pkg::VEL_DIV));
                peak_level    = 16'(32'(it.velocity) *
                                (adsr_dac_pkg::MAX_LEVEL_INT / adsr_dac_pkg::VEL_DIV));
                held_key      = it.note;
            end
            adsr_dac_pkg::MODE_OFF_MATCH: begin
                if (held_key == it.note) gain_stage = adsr_dac_pkg::STAGE_RELEASE;
            end
            default: gain_stage = adsr_dac_pkg::STAGE_RELEASE;
        endcase
        r.level = gain_level;
        r.stage = gain_stage;
        return r;
    endfunction

    // result checker
    always @(posedge aclk) begin
        dac_beat_t want;
        dac_beat_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.dac_word = m_tdata[13:0];
            got.level    = m_tdata[29:14];
            got.stage    = adsr_dac_pkg::env_stage_t'(m_tdata[32:30]);
            if (pending_dac_beats.size() == 0) begin
                $error("result beat with nothing expected: %h", m_tdata);
                mismatches++;
            end else begin
                want = pending_dac_beats.pop_front();
                if (got.dac_word !== want.dac_word) begin
                    $error("dac_word expected %h actual %h", want.dac_word, got.dac_word);
                    mismatches++;
                end
                if (got.level !== want.level) begin
                    $error("level expected %0d actual %0d", want.level, got.level);
                    mismatches++;
                end
                if (got.stage !== want.stage) begin
                    $error("stage expected %0d actual %0d", want.stage, got.stage);
                    mismatches++;
                end
            end
        end
    end

    // result side ready, with random stalls and a long hold-off on request
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !(idle_on && $urandom_range(99) < 7);
        end
    end

    task automatic reg_write(input adsr_dac_pkg::reg_index_t idx, input logic [31:0] value);
        logic [31:0] stored;
        stored = (idx == adsr_dac_pkg::REG_ENABLE) ? (value & 32'h1) : (value & 32'hFFFF);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== stored) begin
            $error("register %0d expected %h actual %h", idx, stored, prdata);
            mismatches++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            adsr_dac_pkg::REG_ENABLE:       shadow_enable       = stored[0];
            adsr_dac_pkg::REG_ATTACK_STEP:  shadow_attack       = stored[15:0];
            adsr_dac_pkg::REG_DECAY_STEP:   shadow_decay        = stored[15:0];
            adsr_dac_pkg::REG_RELEASE_STEP: shadow_release      = stored[15:0];
            adsr_dac_pkg::REG_SUSTAIN_BASE: shadow_sustain_base = stored[15:0];
            default: ;
        endcase
    endtask

    task automatic configure_envelope(input logic en, input logic [15:0] attack,
                                      input logic [15:0] decay, input logic [15:0] rel,
                                      input logic [15:0] sus_base);
        reg_write(adsr_dac_pkg::REG_ENABLE, {31'b0, en});
        reg_write(adsr_dac_pkg::REG_ATTACK_STEP, {16'b0, attack});
        reg_write(adsr_dac_pkg::REG_DECAY_STEP, {16'b0, decay});
        reg_write(adsr_dac_pkg::REG_RELEASE_STEP, {16'b0, rel});
        reg_write(adsr_dac_pkg::REG_SUSTAIN_BASE, {16'b0, sus_base});
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_item(input note_item_t it);
        while (idle_on && $urandom_range(99) < 7) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, it.sample, it.velocity, it.note};
        s_tuser  <= it.mode;
        do @(posedge aclk); while (!s_tready);
        pending_dac_beats.push_back(envelope_next(it));
        @(negedge aclk);
    endtask

    task automatic send_fields(input adsr_dac_pkg::item_mode_t mode, input logic [6:0] note,
                               input logic [6:0] velocity, input logic [15:0] sample);
        note_item_t it;
        it.mode     = mode;
        it.note     = note;
        it.velocity = velocity;
        it.sample   = sample;
        send_item(it);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_dac_beats.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic note_item_t random_item();
        note_item_t it;
        int         pick;
        pick        = $urandom_range(99);
        it.note     = 7'($urandom);
        it.velocity = 7'($urandom);
        it.sample   = 16'($urandom);
        if (pick < 8) begin
            it.mode = adsr_dac_pkg::MODE_NOTE_ON;
        end else if (pick < 13) begin
            it.mode = adsr_dac_pkg::MODE_OFF_MATCH;
            if ($urandom_range(3) != 0) it.note = held_key;
        end else if (pick < 16) begin
            it.mode = adsr_dac_pkg::MODE_OFF_ANY;
        end else begin
            it.mode = adsr_dac_pkg::MODE_TICK;
        end
        return it;
    endfunction

    task automatic test_disabled_envelope();
        send_fields(adsr_dac_pkg::MODE_TICK, 7'd0, 7'd0, 16'hFFFF);
        send_fields(adsr_dac_pkg::MODE_TICK, 7'd0, 7'd0, 16'h0000);
        send_fields(adsr_dac_pkg::MODE_NOTE_ON, 7'd127, 7'd127, 16'hFFFF);
        send_fields(adsr_dac_pkg::MODE_TICK, 7'd127, 7'd127, 16'h8000);
        drain_results();
    endtask

    task automatic test_envelope_stages();
        configure_envelope(1'b1, 16'd792, 16'd38, 16'd4096, 16'd15360);
        // attack wraps past full scale after the disabled phase
        send_fields(adsr_dac_pkg::MODE_TICK, 7'd0, 7'd0, 16'hFFFF);
        send_fields(adsr_dac_pkg::MODE_OFF_ANY, 7'd0, 7'd0, 16'h1234);
        send_fields(adsr_dac_pkg::MODE_TICK, 7'd0, 7'd0, 16'hFFFF);
        send_fields(adsr_dac_pkg::MODE_TICK, 7'd0, 7'd0, 16'hFFFF);
        send_fields(adsr_dac_pkg::MODE_OFF_MATCH, 7'd3, 7'd0, 16'h0);
        // release from idle
        send_fields(adsr_dac_pkg::MODE_OFF_MATCH, 7'd127, 7'd0, 16'h0);
        send_fields(adsr_dac_pkg::MODE_TICK, 7'd0, 7'd0, 16'hFFFF);
        // zero velocity: peak and sustain both zero, decay wraps below zero
        send_fields(adsr_dac_pkg::MODE_NOTE_ON, 7'd0, 7'd0, 16'hFFFF);
        send_fields(adsr_dac_pkg::MODE_TICK, 7'd0, 7'd0, 16'hFFFF);
        send_fields(adsr_dac_pkg::MODE_TICK, 7'd0, 7'd0, 16'hFFFF);
        send_fields(adsr_dac_pkg::MODE_TICK, 7'd0, 7'd0, 16'hFFFF);
        send_fields(adsr_dac_pkg::MODE_NOTE_ON, 7'd64, 7'd127, 16'h0);
        send_fields(adsr_dac_pkg::MODE_TICK, 7'd0, 7'd0, 16'hFFFF);
        send_fields(adsr_dac_pkg::MODE_TICK, 7'd0, 7'd0, 16'h7FFF);
        send_fields(adsr_dac_pkg::MODE_TICK, 7'd0, 7'd0, 16'h0001);
        send_fields(adsr_dac_pkg::MODE_OFF_MATCH, 7'd64, 7'd0, 16'h0);
        send_fields(adsr_dac_pkg::MODE_TICK, 7'd0, 7'd0, 16'hFFFF);
        drain_results();
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: configure_envelope(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                1: configure_envelope(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
                default: configure_envelope($urandom_range(9) != 0,
                                            16'($urandom_range(8000, 1)),
                                            16'($urandom_range(4000, 1)),
                                            16'($urandom_range(4000, 1)),
                                            16'($urandom));
            endcase
            idle_on = (phase != 2);
            @(negedge aclk);
            for (int n = 0; n < PHASE_BEATS; n++) send_item(random_item());
            drain_results();
        end
        idle_on = 1'b1;
    endtask

    task automatic test_backpressure();
        configure_envelope(1'b1, 16'd2000, 16'd300, 16'd500, 16'd30000);
        @(negedge aclk);
        hold_request = 1'b1;
        for (int n = 0; n < 60; n++) send_item(random_item());
        drain_results();
    endtask

    initial begin
        gain_level          = '0;
        gain_stage          = adsr_dac_pkg::STAGE_IDLE;
        peak_level          = '0;
        sustain_level       = '0;
        held_key            = '0;
        shadow_enable       = 1'b0;
        shadow_attack       = adsr_dac_pkg::ATTACK_STEP_RST;
        shadow_decay        = adsr_dac_pkg::DECAY_STEP_RST;
        shadow_release      = adsr_dac_pkg::RELEASE_STEP_RST;
        shadow_sustain_base = adsr_dac_pkg::SUSTAIN_BASE_RST;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_disabled_envelope();
        test_envelope_stages();
        test_random_phases();
        test_backpressure();
        drain_results();
        if (mismatches == 0) begin
            $display("adsr_envelope_dac_stage_core regression: pass");
        end else begin
            $display("adsr_envelope_dac_stage_core regression: fail");
        end
        $finish;
    end

endmodule
